// ===== rtl/max_pool_2d_stream_top_macros.svh =====
// Assertion macros for the max pooling block. They expect clk and rst_n in scope.
`ifndef MAX_POOL_2D_STREAM_TOP_MACROS_SVH
`define MAX_POOL_2D_STREAM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MP2D_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MP2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mp2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mp2d_pkg;

    localparam int POOL_H_DEF   = 2;
    localparam int POOL_W_DEF   = 2;
    localparam int OUT_H_DEF    = 16;
    localparam int OUT_W_DEF    = 16;
    localparam int CHANNELS_DEF = 8;
    localparam int DATA_W_DEF   = 16;

    // Output queue: four words, count runs 0..4.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Width of a counter over 0..n-1, at least one bit.
    function automatic int cnt_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mp2d_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mp2d_sample_if #(
    parameter int DATA_W = mp2d_pkg::DATA_W_DEF
);
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/mp2d_pooled_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface mp2d_pooled_if #(
    parameter int DATA_W = mp2d_pkg::DATA_W_DEF
);
    logic              valid;
    logic              ready;
    logic [DATA_W-2:0] pooled;
    logic              frame_last;

    modport source (output valid, output pooled, output frame_last, input ready);
    modport sink (input valid, input pooled, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/mp2d_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mp2d_out_fifo #(
    parameter int W = mp2d_pkg::DATA_W_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire logic [W-1:0]            push_data,
    output logic                         pop_valid,
    input  wire logic                    pop_ready,
    output logic [W-1:0]                 pop_data,
    output logic [mp2d_pkg::OQ_CW-1:0]   count
);
    import mp2d_pkg::*;

    logic [W-1:0]     mem [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg;
    logic [OQ_AW-1:0] rd_ptr_reg;
    logic [OQ_CW-1:0] count_reg;
    logic [OQ_CW-1:0] count_next;
    logic             pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OQ_CW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - OQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OQ_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OQ_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/max_pool_2d_stream_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming non-overlapping POOL_H x POOL_W max pooling over a feature map that arrives
// row by row, column by column, channel fastest. Each result is the maximum of zero and
// the window's samples, sent when the window's last sample arrives, with frame_last on
// the final result of a frame. The block takes one sample word per cycle while ready is
// high: each sample does one read of the running-maximum memory in its accept cycle and
// one compare and write back in the next. A four-word output queue decouples the result
// side; ready drops only while that queue, counting the result still being formed, holds
// three or more words. The memory needs no clearing pass after reset, since the first
// sample of a window always overwrites its entry.
module max_pool_2d_stream_top #(
    parameter int POOL_H   = mp2d_pkg::POOL_H_DEF,
    parameter int POOL_W   = mp2d_pkg::POOL_W_DEF,
    parameter int OUT_H    = mp2d_pkg::OUT_H_DEF,
    parameter int OUT_W    = mp2d_pkg::OUT_W_DEF,
    parameter int CHANNELS = mp2d_pkg::CHANNELS_DEF,
    parameter int DATA_W   = mp2d_pkg::DATA_W_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    mp2d_sample_if.sink   samples,
    mp2d_pooled_if.source results
);
    import mp2d_pkg::*;
    `include "max_pool_2d_stream_top_macros.svh"

    localparam int DEPTH = OUT_W * CHANNELS;
    localparam int AW    = cnt_w(DEPTH);
    localparam int MW    = DATA_W - 1;
    localparam int CH_W  = cnt_w(CHANNELS);
    localparam int WC_W  = cnt_w(POOL_W);
    localparam int WR_W  = cnt_w(POOL_H);
    localparam int OC_W  = cnt_w(OUT_W);
    localparam int OR_W  = cnt_w(OUT_H);

    // Position of the next sample.
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [WC_W-1:0] wcol_reg, wcol_next;
    logic [OC_W-1:0] ocol_reg, ocol_next;
    logic [WR_W-1:0] wrow_reg, wrow_next;
    logic [OR_W-1:0] orow_reg, orow_next;

    logic          accept;
    logic [AW-1:0] addr;
    logic [MW-1:0] clamped;
    logic          first_win;
    logic          done_win;
    logic          last_frame;

    // Second stage: read data arrives, compare and write back.
    logic          s1_valid_reg;
    logic          s1_first_reg;
    logic          s1_done_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [MW-1:0] s1_val_reg;
    logic [MW-1:0] rd_data_reg;
    logic [MW-1:0] s1_base;
    logic [MW-1:0] s1_new;

    // Last write, for a read that was issued on the same edge as that write.
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [MW-1:0] fwd_data_reg;

    logic [MW-1:0] mem [DEPTH];

    logic             push;
    logic [OQ_CW-1:0] oq_count;
    logic [OQ_CW-1:0] oq_used;

    assign accept  = samples.valid && samples.ready;
    assign clamped = samples.sample[DATA_W-1] ? '0 : samples.sample[DATA_W-2:0];
    assign addr    = AW'(ocol_reg) * AW'(CHANNELS) + AW'(ch_reg);

    assign first_win  = (wrow_reg == '0) && (wcol_reg == '0);
    assign done_win   = (wrow_reg == WR_W'(POOL_H - 1)) && (wcol_reg == WC_W'(POOL_W - 1));
    assign last_frame = done_win && (orow_reg == OR_W'(OUT_H - 1))
                        && (ocol_reg == OC_W'(OUT_W - 1)) && (ch_reg == CH_W'(CHANNELS - 1));

    // A result in the second stage still needs a queue slot.
    assign oq_used       = oq_count + OQ_CW'(s1_valid_reg && s1_done_reg);
    assign samples.ready = (oq_used < OQ_CW'(OQ_DEPTH - 1));

    always_comb
    begin
        ch_next   = ch_reg;
        wcol_next = wcol_reg;
        ocol_next = ocol_reg;
        wrow_next = wrow_reg;
        orow_next = orow_reg;
        if (ch_reg == CH_W'(CHANNELS - 1))
        begin
            ch_next = '0;
            if (wcol_reg == WC_W'(POOL_W - 1))
            begin
                wcol_next = '0;
                if (ocol_reg == OC_W'(OUT_W - 1))
                begin
                    ocol_next = '0;
                    if (wrow_reg == WR_W'(POOL_H - 1))
                    begin
                        wrow_next = '0;
                        if (orow_reg == OR_W'(OUT_H - 1))
                        begin
                            orow_next = '0;
                        end
                        else
                        begin
                            orow_next = orow_reg + OR_W'(1);
                        end
                    end
                    else
                    begin
                        wrow_next = wrow_reg + WR_W'(1);
                    end
                end
                else
                begin
                    ocol_next = ocol_reg + OC_W'(1);
                end
            end
            else
            begin
                wcol_next = wcol_reg + WC_W'(1);
            end
        end
        else
        begin
            ch_next = ch_reg + CH_W'(1);
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            s1_base = fwd_data_reg;
        end
        else
        begin
            s1_base = rd_data_reg;
        end
        if (s1_first_reg || (s1_val_reg > s1_base))
        begin
            s1_new = s1_val_reg;
        end
        else
        begin
            s1_new = s1_base;
        end
    end

    assign push = s1_valid_reg && s1_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg        <= '0;
            wcol_reg      <= '0;
            ocol_reg      <= '0;
            wrow_reg      <= '0;
            orow_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ch_reg   <= ch_next;
                wcol_reg <= wcol_next;
                ocol_reg <= ocol_next;
                wrow_reg <= wrow_next;
                orow_reg <= orow_next;
            end
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg <= first_win;
            s1_done_reg  <= done_win;
            s1_last_reg  <= last_frame;
            s1_addr_reg  <= addr;
            s1_val_reg   <= clamped;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= s1_new;
    end

    // Running-maximum memory: one read port, one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[addr];
        end
        if (s1_valid_reg)
        begin
            mem[s1_addr_reg] <= s1_new;
        end
    end

    mp2d_out_fifo #(
        .W(DATA_W)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({s1_last_reg, s1_new}),
        .pop_valid (results.valid),
        .pop_ready (results.ready),
        .pop_data  ({results.frame_last, results.pooled}),
        .count     (oq_count)
    );

    `MP2D_ASSERT_SAME(a_queue_room, push, oq_count < OQ_CW'(OQ_DEPTH), "result pushed into a full queue")
    `MP2D_ASSERT_SAME(a_last_wraps, s1_valid_reg && s1_last_reg && s1_done_reg, (ch_reg == '0) && (wcol_reg == '0) && (ocol_reg == '0) && (wrow_reg == '0) && (orow_reg == '0), "position did not wrap after the final word of a frame")
    `MP2D_ASSERT_NEXT(a_queue_used, samples.valid && samples.ready, oq_count <= OQ_CW'(OQ_DEPTH - 1), "sample accepted without queue credit")

endmodule
`default_nettype wire
